// ----- hdl/byte_escape_encode_decode_core_macros.svh -----
// Assertion macros used by the checker file of the escape codec.
`ifndef BYTE_ESCAPE_ENCODE_DECODE_CORE_MACROS_SVH
`define BYTE_ESCAPE_ENCODE_DECODE_CORE_MACROS_SVH

// Property checked only while the block is out of reset.
`define BEC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property that is also checked across reset itself.
`define BEC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/bec_pkg.sv -----
// ----------------------------------------------------------------------------
// Escape codec package
// Shared types, character constants and helper functions of the codec.
// ----------------------------------------------------------------------------
package bec_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] PRINT_LOW      = 8'h20;
   localparam logic [7:0] PRINT_HIGH     = 8'h7E;

   // Decode escape phases.
   localparam logic [1:0] PH_NORMAL = 2'd0;
   localparam logic [1:0] PH_ESC    = 2'd1;
   localparam logic [1:0] PH_HIGH   = 2'd2;
   localparam logic [1:0] PH_LOW    = 2'd3;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One job for the back end: up to four result characters.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            byte_valid;
      logic            done;
      logic            err;
   } job_type;

   function automatic logic [7:0] hex_upper(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'h0, nib};
      end else begin
         r = 8'h37 + {4'h0, nib};
      end
      return r;
   endfunction

   // Letters count from ten, anything else counts from '0' with wrap-around.
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] r;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         r = c - 8'h37;
      end else begin
         r = c - 8'h30;
      end
      return r;
   endfunction

endpackage

// ----- hdl/bec_front.sv -----
// ----------------------------------------------------------------------------
// Escape codec front end
// Classifies each accepted request, keeps the decode state and builds a job.
// ----------------------------------------------------------------------------
module bec_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             end_of_message,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   output logic             job_push,
   output bec_pkg::job_type job
);

   logic       direction_ff, direction_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] partial_ff, partial_in;
   logic       err_ff, err_in;

   logic [1:0] dec_phase;
   logic [7:0] dec_partial;
   logic       dec_err;
   logic       dec_have;
   logic [7:0] dec_byte;
   logic [7:0] dv;

   assign dv = bec_pkg::digit_value(in_byte);

   always_comb begin
      dec_phase   = phase_ff;
      dec_partial = partial_ff;
      dec_err     = err_ff;
      dec_have    = 1'b0;
      dec_byte    = 8'h00;
      if (!err_ff) begin
         case (phase_ff)
            bec_pkg::PH_NORMAL: begin
               if (in_byte == bec_pkg::CHAR_BACKSLASH) begin
                  dec_phase = bec_pkg::PH_ESC;
               end else begin
                  dec_have = 1'b1;
                  dec_byte = in_byte;
               end
            end
            bec_pkg::PH_ESC: begin
               if (in_byte == bec_pkg::CHAR_BACKSLASH) begin
                  dec_have  = 1'b1;
                  dec_byte  = bec_pkg::CHAR_BACKSLASH;
                  dec_phase = bec_pkg::PH_NORMAL;
               end else if (in_byte == bec_pkg::CHAR_LOWER_X) begin
                  dec_phase = bec_pkg::PH_HIGH;
               end else begin
                  dec_err   = 1'b1;
                  dec_phase = bec_pkg::PH_NORMAL;
               end
            end
            bec_pkg::PH_HIGH: begin
               dec_partial = {dv[3:0], 4'h0};
               dec_phase   = bec_pkg::PH_LOW;
            end
            bec_pkg::PH_LOW: begin
               dec_have    = 1'b1;
               dec_byte    = partial_ff + dv;
               dec_phase   = bec_pkg::PH_NORMAL;
               dec_partial = 8'h00;
            end
            default: begin
               dec_phase = bec_pkg::PH_NORMAL;
            end
         endcase
      end
   end

   always_comb begin
      job        = '0;
      job_push   = 1'b0;
      phase_in   = phase_ff;
      partial_in = partial_ff;
      err_in     = err_ff;
      if (direction_ff == bec_pkg::DIR_ENCODE) begin
         job.byte_valid = 1'b1;
         job.done       = end_of_message;
         job_push       = 1'b1;
         if (in_byte == bec_pkg::CHAR_BACKSLASH) begin
            job.chars[0] = bec_pkg::CHAR_BACKSLASH;
            job.chars[1] = bec_pkg::CHAR_BACKSLASH;
            job.last_idx = 2'd1;
         end else if (in_byte >= bec_pkg::PRINT_LOW && in_byte <= bec_pkg::PRINT_HIGH) begin
            job.chars[0] = in_byte;
            job.last_idx = 2'd0;
         end else begin
            job.chars[0] = bec_pkg::CHAR_BACKSLASH;
            job.chars[1] = bec_pkg::CHAR_LOWER_X;
            job.chars[2] = bec_pkg::hex_upper(in_byte[7:4]);
            job.chars[3] = bec_pkg::hex_upper(in_byte[3:0]);
            job.last_idx = 2'd3;
         end
      end else begin
         job.chars[0]   = dec_byte;
         job.last_idx   = 2'd0;
         job.byte_valid = dec_have;
         if (end_of_message) begin
            // The closing request always yields one result, possibly status only.
            job_push   = 1'b1;
            job.done   = 1'b1;
            job.err    = dec_err || (dec_phase != bec_pkg::PH_NORMAL);
            phase_in   = bec_pkg::PH_NORMAL;
            partial_in = 8'h00;
            err_in     = 1'b0;
         end else begin
            job_push   = dec_have;
            phase_in   = dec_phase;
            partial_in = dec_partial;
            err_in     = dec_err;
         end
      end
   end

   assign direction_in = csr_wr_en ? csr_wr_data : direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= bec_pkg::DIR_ENCODE;
         phase_ff     <= bec_pkg::PH_NORMAL;
         partial_ff   <= 8'h00;
         err_ff       <= 1'b0;
      end else if (csr_wr_en) begin
         direction_ff <= direction_in;
         phase_ff     <= bec_pkg::PH_NORMAL;
         partial_ff   <= 8'h00;
         err_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         partial_ff   <= partial_in;
         err_ff       <= err_in;
      end
   end

endmodule

// ----- hdl/bec_queue.sv -----
// ----------------------------------------------------------------------------
// Escape codec job queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module bec_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  bec_pkg::job_type wr_job,
   input  logic             rd_en,
   output bec_pkg::job_type rd_job,
   output logic             q_empty,
   output logic             q_full
);

   bec_pkg::job_type                     slot_ff [bec_pkg::QUEUE_DEPTH];
   logic [bec_pkg::QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [bec_pkg::QPTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [bec_pkg::QCNT_W-1:0]           count_ff, count_in;
   logic                                 do_wr, do_rd;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == bec_pkg::QCNT_W'(bec_pkg::QUEUE_DEPTH));
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == bec_pkg::QPTR_W'(bec_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == bec_pkg::QPTR_W'(bec_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ----- hdl/bec_back.sv -----
// ----------------------------------------------------------------------------
// Escape codec back end
// Holds the current job and issues its results one per cycle while pop is high.
// ----------------------------------------------------------------------------
module bec_back (
   input  logic             clock,
   input  logic             reset,
   input  bec_pkg::job_type q_job,
   input  logic             q_empty,
   output logic             q_rd,
   input  logic             pop,
   output logic             empty,
   output logic [7:0]       out_byte,
   output logic             byte_valid,
   output logic             last_of_run,
   output logic             message_done,
   output logic             decode_error
);

   bec_pkg::job_type job_ff, job_in;
   logic             busy_ff, busy_in;
   logic [1:0]       idx_ff, idx_in;
   logic             is_last;
   logic             advance;

   assign is_last = (idx_ff == job_ff.last_idx);
   // Move to the next job when idle or when the final result of this one leaves.
   assign advance = !busy_ff || (pop && is_last);
   assign q_rd    = advance && !q_empty;

   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (advance) begin
         job_in  = q_job;
         busy_in = !q_empty;
         idx_in  = 2'd0;
      end else if (pop) begin
         idx_in  = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign empty        = !busy_ff;
   assign byte_valid   = job_ff.byte_valid;
   assign out_byte     = job_ff.byte_valid ? job_ff.chars[idx_ff] : 8'h00;
   assign last_of_run  = is_last;
   assign message_done = job_ff.done && is_last;
   assign decode_error = job_ff.err;

endmodule

// ----- hdl/byte_escape_encode_decode_core.sv -----
// An accepted request passes through the job queue into the back end's job register
// before its first result shows. One request per cycle is taken while each yields a
// single result popped at once; a run of up to four characters holds the result port.
// The two-entry job queue lets requests be taken while results wait to be popped.
// Reset is synchronous and active high; it clears the queue, the decode state
// and the direction (encode).
// ----------------------------------------------------------------------------
// Backslash/hex escape codec
// Encodes raw bytes into escaped text or decodes escaped text into bytes.
// ----------------------------------------------------------------------------
module byte_escape_encode_decode_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_message,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last_of_run,
   output logic       rsp_message_done,
   output logic       rsp_decode_error,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   bec_pkg::job_type front_job, q_job;
   logic             front_push;
   logic             accept;
   logic             q_empty, q_full, q_rd;

   assign full   = q_full;
   assign accept = push && !q_full;

   bec_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .in_byte        (req_in_byte),
      .end_of_message (req_end_of_message),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .job_push       (front_push),
      .job            (front_job)
   );

   bec_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && front_push),
      .wr_job  (front_job),
      .rd_en   (q_rd),
      .rd_job  (q_job),
      .q_empty (q_empty),
      .q_full  (q_full)
   );

   bec_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_job        (q_job),
      .q_empty      (q_empty),
      .q_rd         (q_rd),
      .pop          (pop),
      .empty        (empty),
      .out_byte     (rsp_out_byte),
      .byte_valid   (rsp_byte_valid),
      .last_of_run  (rsp_last_of_run),
      .message_done (rsp_message_done),
      .decode_error (rsp_decode_error)
   );

endmodule

// ----- hdl/bec_checker.sv -----
// ----------------------------------------------------------------------------
// Escape codec port checker
// Watches the top-level ports and flags results that break the codec rules.
// ----------------------------------------------------------------------------
`include "byte_escape_encode_decode_core_macros.svh"

module bec_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_last_of_run,
   input logic       rsp_message_done,
   input logic       rsp_decode_error
);

   // A waiting result must hold until it is popped.
   `BEC_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(rsp_out_byte)), "result changed before pop")
   // A status-only result carries a zero byte.
   `BEC_ASSERT(a_status_zero, (!empty && !rsp_byte_valid) |-> (rsp_out_byte == 8'h00 && rsp_message_done), "status result malformed")
   // Closing a message is always the final result of its request.
   `BEC_ASSERT(a_done_is_last, (!empty && rsp_message_done) |-> rsp_last_of_run, "message closed mid-run")
   // An error is reported only on the closing result.
   `BEC_ASSERT(a_error_on_close, (!empty && rsp_decode_error) |-> rsp_message_done, "error outside closing result")
   // Reset leaves both sides idle.
   `BEC_ASSERT_RST(a_reset_idle, reset |=> (empty && !full), "not idle after reset")

endmodule

bind byte_escape_encode_decode_core bec_checker u_bec_checker (
   .clock            (clock),
   .reset            (reset),
   .full             (full),
   .empty            (empty),
   .pop              (pop),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_byte_valid   (rsp_byte_valid),
   .rsp_last_of_run  (rsp_last_of_run),
   .rsp_message_done (rsp_message_done),
   .rsp_decode_error (rsp_decode_error)
);
